[hw/rtl/calint_pkg.sv]
// ---------------------------------------------------------------------------
// calint_pkg
// Shared types and codes for the calibration table interpolator.
// ---------------------------------------------------------------------------
package calint_pkg;

   // Request codes carried on req_type
   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_FORWARD = 2'd1,
      REQ_INVERSE = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_code_type;

   // Sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_FIRST = 9'b000000010,
      ST_LAST  = 9'b000000100,
      ST_SCAN  = 9'b000001000,
      ST_MUL   = 9'b000010000,
      ST_PREP  = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_FIN   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   localparam int ROT_W     = 32;
   localparam int ROLL_W    = 16;
   localparam int ENTRY_W   = ROT_W + ROLL_W;
   localparam int PROD_W    = 50;
   localparam int DIVD_W    = 52;
   localparam int DVSR_W    = 34;
   localparam int QUOT_W    = 34;

endpackage

[hw/rtl/calint_ram.sv]
// ---------------------------------------------------------------------------
// calint_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module calint_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry through registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[hw/rtl/calibration_table_interpolator.sv]
// ---------------------------------------------------------------------------
// calibration_table_interpolator
// Piecewise linear lookup between rotation count and roll angle.
// ---------------------------------------------------------------------------
// A load word writes one calibration point and gives no result. A forward
// or inverse conversion reads the first and last points, then walks the
// table one segment per cycle from the table RAM's single read port until
// it finds the bracketing segment, multiplies once, and divides with a
// restoring divider that retires one quotient bit per cycle. A clamped or
// zero-width answer skips the multiply and divide; req_ready is low while
// a conversion is in flight. Table entries must be loaded before a
// conversion reads them.
// ---------------------------------------------------------------------------
module calibration_table_interpolator
   import calint_pkg::*;
#(
   parameter int MAX_ENTRIES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [4:0]          req_entry_index,
   input  logic signed [31:0]  req_entry_rotations,
   input  logic signed [15:0]  req_entry_roll,
   input  logic signed [31:0]  req_query_rotations,
   input  logic signed [15:0]  req_query_roll,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_roll_out,
   output logic signed [31:0]  rsp_rotations_out,
   output logic                rsp_clamped,
   input  logic                csr_wr_en,
   input  logic [5:0]          csr_wr_data
);

   localparam int AW = $clog2(MAX_ENTRIES);

   state_type                state_ff, state_in;
   logic [5:0]               count_cfg_ff;
   logic                     fwd_ff;
   logic signed [31:0]       query_ff;
   logic [AW-1:0]            last_ff, last_in;
   logic [AW-1:0]            idx_ff;
   logic signed [31:0]       first_x_ff, first_y_ff;
   logic                     inc_ff;
   logic signed [31:0]       prev_x_ff, prev_y_ff;
   logic signed [32:0]       dq_ff, dy_ff, dd_ff;
   logic signed [31:0]       y0_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [DIVD_W-1:0]        divd_ff;
   logic [DVSR_W-1:0]        dvsr_ff;
   logic [DVSR_W-1:0]        rem_ff;
   logic                     neg_ff;
   logic [5:0]               step_ff;
   logic signed [31:0]       res_ff;
   logic                     clamp_ff;
   logic                     rsp_valid_ff;
   logic signed [15:0]       roll_out_ff;
   logic signed [31:0]       rot_out_ff;
   logic                     clamp_out_ff;

   logic                     accept;
   logic                     load_ok;
   logic [AW-1:0]            rd_addr;
   logic [ENTRY_W-1:0]       rd_data;
   logic signed [31:0]       rd_x, rd_y, qv;
   logic [10:0]              cfg_ext;
   logic                     in_seg;
   logic signed [32:0]       seg_dq, seg_dy, seg_dd;
   logic signed [32:0]       mul_a;
   logic signed [16:0]       mul_b;
   logic [PROD_W-1:0]        un;
   logic [32:0]              ud;
   logic [DVSR_W:0]          rem_sh;
   logic [DVSR_W:0]          rem_sub;
   logic signed [34:0]       res_sum;
   logic signed [34:0]       quot_s;

   assign accept  = req_valid && req_ready;
   assign load_ok = 11'(req_entry_index) < 11'(MAX_ENTRIES);

   // Table RAM: rotation count in the upper bits, roll in the lower
   calint_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (accept && (req_type == REQ_LOAD) && load_ok),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_entry_rotations, req_entry_roll}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pick axis and value columns by direction
   always_comb begin
      if (fwd_ff) begin
         rd_x = signed'(rd_data[ENTRY_W-1:ROLL_W]);
         rd_y = {{16{rd_data[ROLL_W-1]}}, rd_data[ROLL_W-1:0]};
      end else begin
         rd_x = {{16{rd_data[ROLL_W-1]}}, rd_data[ROLL_W-1:0]};
         rd_y = signed'(rd_data[ENTRY_W-1:ROLL_W]);
      end
      qv = query_ff;
   end

   // Clamp the entry count into 2..MAX_ENTRIES and keep the last index
   always_comb begin
      cfg_ext = 11'(count_cfg_ff);
      if (cfg_ext < 11'd2) begin
         last_in = AW'(1);
      end else if (cfg_ext > 11'(MAX_ENTRIES)) begin
         last_in = AW'(MAX_ENTRIES - 1);
      end else begin
         last_in = AW'(cfg_ext - 11'd1);
      end
   end

   // Drive the read address ahead of the state that consumes it
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  rd_addr = '0;
         ST_FIRST: rd_addr = last_ff;
         ST_LAST:  rd_addr = AW'(1);
         ST_SCAN:  rd_addr = idx_ff + AW'(1);
         default:  rd_addr = '0;
      endcase
   end

   // Segment test and differences
   always_comb begin
      in_seg = inc_ff ? (qv >= prev_x_ff && qv <= rd_x) : (qv <= prev_x_ff && qv >= rd_x);
      seg_dq = 33'(qv) - 33'(prev_x_ff);
      seg_dy = 33'(rd_y) - 33'(prev_y_ff);
      seg_dd = 33'(rd_x) - 33'(prev_x_ff);
      if (fwd_ff) begin
         mul_a = dq_ff;
         mul_b = dy_ff[16:0];
      end else begin
         mul_a = dy_ff;
         mul_b = dq_ff[16:0];
      end
      un      = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      ud      = dd_ff[32] ? 33'(-dd_ff) : 33'(dd_ff);
      rem_sh  = {rem_ff, divd_ff[DIVD_W-1]};
      rem_sub = rem_sh - {1'b0, dvsr_ff};
      quot_s  = signed'({1'b0, divd_ff[QUOT_W-1:0]});
      res_sum = 35'(y0_ff) + (neg_ff ? -quot_s : quot_s);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_FORWARD || req_type == REQ_INVERSE)) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: state_in = ST_LAST;
         ST_LAST: begin
            if ((rd_x >= first_x_ff) ? (qv <= first_x_ff || qv >= rd_x)
                                     : (qv >= first_x_ff || qv <= rd_x)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (in_seg) begin
               state_in = (seg_dd == '0) ? ST_DONE : ST_MUL;
            end else if (idx_ff == last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_MUL:  state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  state_in = (step_ff == 6'd1) ? ST_FIN : ST_DIV;
         ST_FIN:  state_in = ST_DONE;
         ST_DONE: state_in = (!rsp_valid_ff || rsp_ready) ? ST_IDLE : ST_DONE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_cfg_ff <= 6'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            count_cfg_ff <= csr_wr_data;
         end
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            // Latch the query and direction
            fwd_ff   <= (req_type == REQ_FORWARD);
            query_ff <= (req_type == REQ_FORWARD) ? req_query_rotations
                                                  : 32'(req_query_roll);
            last_ff  <= last_in;
         end
         ST_FIRST: begin
            first_x_ff <= rd_x;
            first_y_ff <= rd_y;
         end
         ST_LAST: begin
            // Endpoint checks, else start the walk at the first segment
            prev_x_ff <= first_x_ff;
            prev_y_ff <= first_y_ff;
            idx_ff    <= AW'(1);
            if ((rd_x >= first_x_ff) ? (qv <= first_x_ff) : (qv >= first_x_ff)) begin
               res_ff   <= first_y_ff;
               clamp_ff <= (qv != first_x_ff);
            end else begin
               res_ff   <= rd_y;
               clamp_ff <= (qv != rd_x);
            end
            // Hold the table direction given by the two endpoints
            inc_ff <= (rd_x >= first_x_ff);
         end
         ST_SCAN: begin
            clamp_ff <= 1'b0;
            dq_ff    <= seg_dq;
            dy_ff    <= seg_dy;
            dd_ff    <= seg_dd;
            y0_ff    <= prev_y_ff;
            if (in_seg) begin
               res_ff <= prev_y_ff;
            end else begin
               res_ff    <= rd_y;
               prev_x_ff <= rd_x;
               prev_y_ff <= rd_y;
               idx_ff    <= idx_ff + AW'(1);
            end
         end
         ST_MUL: begin
            // 33 by 17 bit signed product, sign-extended to full width
            prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
         end
         ST_PREP: begin
            // Dividend 2|n| + |d|, divisor 2|d| for round half away from zero
            divd_ff <= DIVD_W'({un, 1'b0}) + DIVD_W'(ud);
            dvsr_ff <= {ud, 1'b0};
            rem_ff  <= '0;
            neg_ff  <= prod_ff[PROD_W-1] ^ dd_ff[32];
            step_ff <= 6'(DIVD_W);
         end
         ST_DIV: begin
            // One restoring step per cycle, quotient shifts into the dividend
            step_ff <= step_ff - 6'd1;
            if (!rem_sub[DVSR_W]) begin
               rem_ff  <= rem_sub[DVSR_W-1:0];
               divd_ff <= {divd_ff[DIVD_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh[DVSR_W-1:0];
               divd_ff <= {divd_ff[DIVD_W-2:0], 1'b0};
            end
         end
         ST_FIN: begin
            res_ff <= res_sum[31:0];
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               roll_out_ff <= fwd_ff ? res_ff[15:0] : 16'sd0;
               rot_out_ff  <= fwd_ff ? 32'sd0 : res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Output clamp flag register
   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         clamp_out_ff <= clamp_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_out      = roll_out_ff;
   assign rsp_rotations_out = rot_out_ff;
   assign rsp_clamped       = clamp_out_ff;

   // Only one of the two result values may be nonzero
   a_one_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_out == 16'sd0 || rsp_rotations_out == 32'sd0))
      else $error("both result values nonzero");

   // Divider leaves only to the final add
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (state_ff == ST_DIV || state_ff == ST_FIN))
      else $error("divider left early");

   // No new word is taken while a conversion is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready while busy");

   // A clamped result never went through the divider
   a_clamp_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |=> !clamp_ff)
      else $error("clamp set after divide");

endmodule
